// ===== hw/rtl/ordered_list_engine_defines.svh =====
// Assertion helpers for the ordered list engine
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define OLE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ordered list engine check failed");

// Consequent must hold in the cycle after the antecedent
`define OLE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ordered list engine check failed");

`endif

// ===== hw/rtl/olist_pkg.sv =====
package olist_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int DATA_W       = 32;

   typedef enum logic [2:0] {
      ACT_INS_FRONT = 3'd0,
      ACT_INS_BACK  = 3'd1,
      ACT_INS_KEY   = 3'd2,
      ACT_DEL_FRONT = 3'd3,
      ACT_DEL_BACK  = 3'd4,
      ACT_DEL_VALUE = 3'd5,
      ACT_SHOW      = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NOCHANGE = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_SCAN,
      CELL_INS,
      CELL_DEL,
      CELL_ROT
   } cell_cmd_type;

   typedef enum logic [1:0] {
      HIT_FRONT,
      HIT_BACK,
      HIT_LAST,
      HIT_MATCH
   } hit_sel_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY,
      S_EMIT
   } state_type;

   typedef struct packed {
      cell_cmd_type        cmd;
      hit_sel_type         hit_sel;
      logic [DATA_W-1:0]   operand;
      logic [DATA_W-1:0]   new_value;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/olist_cell.sv =====
module olist_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  olist_pkg::cell_ctl_type    ctl,
   input  logic [CNT_W-1:0]           count,
   input  logic [olist_pkg::DATA_W-1:0] left_value,
   input  logic [olist_pkg::DATA_W-1:0] right_value,
   input  logic [olist_pkg::DATA_W-1:0] head_value,
   input  logic                       left_carry,
   output logic [olist_pkg::DATA_W-1:0] value,
   output logic                       carry
);
   import olist_pkg::*;

   localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
   localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(IDX + 1);

   logic [DATA_W-1:0] value_ff, value_in;
   logic              before_ff, before_in;
   logic              hit;

   always_comb begin
      case (ctl.hit_sel)
         HIT_FRONT: hit = (IDX_C == '0);
         HIT_BACK:  hit = (IDX_C == count);
         HIT_LAST:  hit = (IDX_P1 == count);
         HIT_MATCH: hit = (IDX_C < count) && (value_ff == ctl.operand);
         default:   hit = 1'b0;
      endcase
   end

   // carry: this cell or one ahead of it holds the target
   assign carry = before_ff | hit;
   assign value = value_ff;

   always_comb begin
      value_in  = value_ff;
      before_in = before_ff;
      case (ctl.cmd)
         CELL_CLEAR: before_in = 1'b0;
         CELL_SCAN:  before_in = left_carry;
         CELL_INS: begin
            if (before_ff) begin
               value_in = left_value;
            end else if (hit) begin
               value_in = ctl.new_value;
            end
         end
         CELL_DEL: begin
            if (carry) begin
               value_in = right_value;
            end
         end
         CELL_ROT: value_in = (IDX_P1 == count) ? head_value : right_value;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         before_ff <= 1'b0;
      end else begin
         before_ff <= before_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== hw/rtl/ordered_list_engine.sv =====
// Ordered list engine: a bounded list of signed 32-bit entries kept in a row
// of cells, each holding one entry.
// Request channel (req_): tuser carries the action, tdata the value and key.
// One request is taken at a time; req_tready is high only while idle.
// Result channel (rsp_): one item per list entry, front to back, tlast on the
// final one; an empty list gives one item with list_empty set and value zero.
// Every result of a request carries the same status.
// Per request: the match flags ripple down the row of cells in the scan state
// (show and rejected requests skip this), the apply state makes the change,
// then one result item per cycle unless the receiver stalls, each rotating
// the row by one.
// The result register lets the next request be taken while the final item
// still waits; a stalled receiver holds rotation and the list is unchanged.
// Reset (synchronous, active high) empties the list and drops any pending
// result; entry contents are not cleared.
`include "ordered_list_engine_defines.svh"

module ordered_list_engine #(
   parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // value [31:0], match_key [63:32]
   input  logic [2:0]  req_tuser,   // action [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // item_value [31:0]
   output logic [2:0]  rsp_tuser,   // list_empty [0], status [2:1]
   output logic        rsp_tlast
);
   import olist_pkg::*;

   localparam int               CNT_W  = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_M1 = CNT_W'(CAPACITY - 1);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  step_ff, step_in;
   action_type        act_ff, act_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [DATA_W-1:0] key_ff, key_in;
   status_type        status_ff, status_in;

   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0]       rsp_tdata_ff, rsp_tdata_in;
   logic [2:0]        rsp_tuser_ff, rsp_tuser_in;
   logic              rsp_tlast_ff, rsp_tlast_in;

   cell_ctl_type      ctl;
   logic [DATA_W-1:0] chain_v [0:CAPACITY+1];
   logic              chain_c [0:CAPACITY];
   logic              found_w;
   logic              is_ins;
   logic              last_w;
   action_type        req_act;

   assign chain_v[0]          = '0;
   assign chain_v[CAPACITY+1] = '0;
   assign chain_c[0]          = 1'b0;
   assign found_w             = chain_c[CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      olist_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .count       (count_ff),
         .left_value  (chain_v[i]),
         .right_value (chain_v[i+2]),
         .head_value  (chain_v[1]),
         .left_carry  (chain_c[i]),
         .value       (chain_v[i+1]),
         .carry       (chain_c[i+1])
      );
   end

   assign req_act = action_type'(req_tuser);
   assign is_ins  = act_ff inside {ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_KEY};
   assign last_w  = (count_ff == '0) || ((step_ff + 1'b1) == count_ff);

   always_comb begin
      ctl.cmd       = CELL_HOLD;
      ctl.new_value = val_ff;
      ctl.operand   = (act_ff == ACT_INS_KEY) ? key_ff : val_ff;
      case (act_ff)
         ACT_INS_FRONT: ctl.hit_sel = HIT_FRONT;
         ACT_INS_BACK:  ctl.hit_sel = HIT_BACK;
         ACT_INS_KEY:   ctl.hit_sel = HIT_MATCH;
         ACT_DEL_FRONT: ctl.hit_sel = HIT_FRONT;
         ACT_DEL_BACK:  ctl.hit_sel = HIT_LAST;
         ACT_DEL_VALUE: ctl.hit_sel = HIT_MATCH;
         default:       ctl.hit_sel = HIT_FRONT;
      endcase

      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      act_in        = act_ff;
      val_in        = val_ff;
      key_in        = key_ff;
      status_in     = status_ff;
      req_tready    = 1'b0;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            ctl.cmd    = CELL_CLEAR;
            if (req_tvalid) begin
               act_in  = req_act;
               val_in  = req_tdata[31:0];
               key_in  = req_tdata[63:32];
               step_in = '0;
               case (req_act)
                  ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_KEY: begin
                     if (count_ff == CAP_C) begin
                        status_in = ST_FULL;
                        state_in  = S_EMIT;
                     end else begin
                        status_in = ST_DONE;
                        state_in  = S_SCAN;
                     end
                  end
                  ACT_DEL_FRONT, ACT_DEL_BACK: begin
                     if (count_ff == '0) begin
                        status_in = ST_NOCHANGE;
                        state_in  = S_EMIT;
                     end else begin
                        status_in = ST_DONE;
                        state_in  = S_SCAN;
                     end
                  end
                  ACT_DEL_VALUE: begin
                     status_in = ST_DONE;
                     state_in  = S_SCAN;
                  end
                  default: begin
                     status_in = ST_DONE;
                     state_in  = S_EMIT;
                  end
               endcase
            end
         end
         S_SCAN: begin
            ctl.cmd = CELL_SCAN;
            step_in = step_ff + 1'b1;
            if (step_ff == CAP_M1) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            step_in  = '0;
            state_in = S_EMIT;
            if (!found_w) begin
               status_in = ST_NOCHANGE;
            end else if (is_ins) begin
               ctl.cmd  = CELL_INS;
               count_in = count_ff + 1'b1;
            end else begin
               ctl.cmd  = CELL_DEL;
               count_in = count_ff - 1'b1;
            end
         end
         S_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = (count_ff == '0) ? '0 : chain_v[1];
               rsp_tuser_in  = {status_ff, (count_ff == '0)};
               rsp_tlast_in  = last_w;
               step_in       = step_ff + 1'b1;
               if (count_ff != '0) begin
                  ctl.cmd = CELL_ROT;
               end
               if (last_w) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         step_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         step_ff       <= step_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      val_ff       <= val_in;
      key_ff       <= key_in;
      status_ff    <= status_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   `OLE_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CAP_C)
   `OLE_ASSERT_NEXT(a_ins_grows, (state_ff == S_APPLY) && found_w && is_ins,
      count_ff == $past(count_ff) + 1'b1)
   `OLE_ASSERT_NOW(a_empty_is_last, rsp_tvalid_ff && rsp_tuser_ff[0], rsp_tlast_ff)
   `OLE_ASSERT_NOW(a_full_no_scan, (state_ff == S_SCAN) && is_ins, count_ff != CAP_C)

endmodule
